>>> rtl/prs_pkg.sv
// Shared types, constants and codes for the propensity reaction selector.
`default_nettype none

package prs_pkg;

	localparam int MAX_REACTIONS_DEF = 256;
	localparam int PROP_BITS_DEF     = 32;

	localparam int NUM_W       = 9;
	localparam int REACT_W     = 8;
	localparam int PROP_IN_W   = 32;
	localparam int FRAC_W      = 32;
	localparam int STATUS_W    = 2;
	localparam int TOTAL_OUT_W = 40;

	// Width of one partial product slice of the threshold multiplier.
	localparam int MUL_W = 32;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_SELECTED    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_REACTION = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_WRITE_DONE  = 2'd2;

	typedef struct packed {
		logic                 operation;
		logic [REACT_W-1:0]   reaction;
		logic [PROP_IN_W-1:0] propensity;
		logic [FRAC_W-1:0]    random_fraction;
	} item_t;

	typedef struct packed {
		logic [REACT_W-1:0]     selected_reaction;
		logic [STATUS_W-1:0]    status;
		logic [TOTAL_OUT_W-1:0] total_out;
	} result_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WRITE,
		S_SCALE,
		S_WALK,
		S_FINISH,
		S_RESULT
	} state_t;

endpackage

`default_nettype wire

>>> rtl/prs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module prs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/prs_threshold.sv
// Multi-cycle threshold unit: floor(fraction * total / 2^32), one 32-bit slice per cycle.
`default_nettype none

module prs_threshold #(
	parameter int TOT_W = 40
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [prs_pkg::FRAC_W-1:0]  frac,
	input  wire logic [TOT_W-1:0]            total,
	output logic                             done,
	output logic      [TOT_W-1:0]            thr
);

	localparam int MW    = prs_pkg::MUL_W;
	localparam int NCH   = (TOT_W + MW - 1) / MW;
	localparam int SH_W  = NCH * MW;
	localparam int ACC_W = SH_W + MW;
	localparam int CNT_W = $clog2(NCH + 1);

	logic [prs_pkg::FRAC_W-1:0] frac_q;
	logic [SH_W-1:0]            tot_sh_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [2*MW-1:0]            prod_s1;
	logic                       mul_v_s1;
	logic [ACC_W-1:0]           acc_q;
	logic                       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			mul_v_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= mul_v_s1 && (cnt_q == '0);
			mul_v_s1 <= (cnt_q != '0);
			if (start) begin
				cnt_q <= CNT_W'(NCH);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Slices are taken most significant first, so the accumulator shifts up by one slice.
	always_ff @(posedge clk) begin
		prod_s1 <= (2*MW)'(frac_q) * (2*MW)'(tot_sh_q[SH_W-1 -: MW]);
		if (start) begin
			frac_q   <= frac;
			tot_sh_q <= SH_W'(total);
			acc_q    <= '0;
		end else begin
			if (cnt_q != '0) begin
				tot_sh_q <= tot_sh_q << MW;
			end
			if (mul_v_s1) begin
				acc_q <= (acc_q << MW) + ACC_W'(prod_s1);
			end
		end
	end

	assign done = done_q;
	assign thr  = acc_q[MW +: TOT_W];

endmodule

`default_nettype wire

>>> rtl/propensity_reaction_selector_top.sv
// Top level of the propensity reaction selector: control, walk pipeline and table memories.
//
//   channel   signals                          carries
//   config    cfg_we, cfg_wdata                num_reactions
//   item      item_valid, item_stall, item     operation, reaction, propensity, fraction
//   result    result_valid, result_stall, result  reaction, status, total
//
// After reset a clearing pass over every address loads the order memory with the
// identity and the propensity memory with zero; items are held off until it ends.
// A write passes through S_WRITE (old value read at acceptance, then update) to S_RESULT.
// A select with zero total goes straight to S_RESULT; otherwise the threshold multiplier
// runs first, then the walk, one order entry per cycle through the order and propensity
// memory reads, over at most the active count of entries; the block then returns to S_IDLE
// before it takes the next item. One item is in work at a time; the result register lets
// the next item enter while a result is still stalled.
`default_nettype none

module propensity_reaction_selector_top #(
	parameter int MAX_REACTIONS = prs_pkg::MAX_REACTIONS_DEF,
	parameter int PROP_BITS     = prs_pkg::PROP_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [prs_pkg::NUM_W-1:0]  cfg_wdata,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire prs_pkg::item_t             item,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output prs_pkg::result_t                result
);

	localparam int AW    = $clog2(MAX_REACTIONS);
	localparam int TOT_W = PROP_BITS + AW;
	localparam int NW    = AW + prs_pkg::NUM_W + 1;

	prs_pkg::state_t state_q, state_d;

	logic [AW-1:0]                 clr_q;
	logic [prs_pkg::NUM_W-1:0]     num_q;
	logic [TOT_W-1:0]              total_q;
	logic [AW-1:0]                 wr_addr_q;
	logic                          wr_ok_q;
	logic [PROP_BITS-1:0]          wr_prop_q;
	logic [AW-1:0]                 iss_q;
	logic                          iss_act_q;
	logic                          v_s1, v_s2;
	logic [AW-1:0]                 pos_s1, pos_s2;
	logic [AW-1:0]                 id_s2;
	logic [TOT_W-1:0]              sum_q;
	logic [AW-1:0]                 held_id_q;
	logic [PROP_BITS-1:0]          held_prop_q;
	logic [AW-1:0]                 res_sel_q;
	logic [prs_pkg::STATUS_W-1:0]  res_status_q;
	logic                          result_valid_q;
	prs_pkg::result_t              result_q;

	logic                 ord_we;
	logic [AW-1:0]        ord_waddr, ord_wdata, ord_rdata;
	logic                 prop_we;
	logic [AW-1:0]        prop_waddr, prop_raddr;
	logic [PROP_BITS-1:0] prop_wdata, prop_rdata;

	logic             thr_start, thr_done;
	logic [TOT_W-1:0] thr;
	logic             accept, load_res;

	logic [AW+prs_pkg::REACT_W-1:0]       r_wide;
	logic                                 r_ok;
	logic [PROP_BITS+prs_pkg::PROP_IN_W-1:0] p_wide, p_max, p_sat_wide;
	logic [NW-1:0]                        nr_wide, last_wide;
	logic [AW-1:0]                        last_pos;

	logic [TOT_W-1:0] sum_n;
	logic             hit, first, at_last, swap;

	logic [AW+prs_pkg::REACT_W-1:0]       sel_wide;
	logic [TOT_W+prs_pkg::TOTAL_OUT_W-1:0] tot_wide;

	// ---------------- Input decode ----------------
	assign item_stall = (state_q != prs_pkg::S_IDLE);
	assign accept     = item_valid && !item_stall;

	assign r_wide = {{AW{1'b0}}, item.reaction};
	assign r_ok   = (r_wide < (AW + prs_pkg::REACT_W)'(MAX_REACTIONS));

	assign p_wide     = {{PROP_BITS{1'b0}}, item.propensity};
	assign p_max      = {{prs_pkg::PROP_IN_W{1'b0}}, {PROP_BITS{1'b1}}};
	assign p_sat_wide = (p_wide > p_max) ? p_max : p_wide;

	// Active count clamped to 1..MAX_REACTIONS, kept as the last position searched.
	always_comb begin
		nr_wide = NW'(num_q);
		if (nr_wide == '0) begin
			last_wide = '0;
		end else if (nr_wide > NW'(MAX_REACTIONS)) begin
			last_wide = NW'(MAX_REACTIONS - 1);
		end else begin
			last_wide = nr_wide - 1'b1;
		end
	end
	assign last_pos = last_wide[AW-1:0];

	// ---------------- Walk stage two ----------------
	assign sum_n   = sum_q + TOT_W'(prop_rdata);
	assign hit     = v_s2 && (sum_n > thr);
	assign first   = (pos_s2 == '0);
	assign at_last = (pos_s2 == last_pos);
	assign swap    = !first && (prop_rdata > held_prop_q);

	// ---------------- Next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prs_pkg::S_CLEAR: begin
				if (clr_q == AW'(MAX_REACTIONS - 1)) begin
					state_d = prs_pkg::S_IDLE;
				end
			end
			prs_pkg::S_IDLE: begin
				if (accept) begin
					if (item.operation == prs_pkg::OP_WRITE) begin
						state_d = prs_pkg::S_WRITE;
					end else if (total_q == '0) begin
						state_d = prs_pkg::S_RESULT;
					end else begin
						state_d = prs_pkg::S_SCALE;
					end
				end
			end
			prs_pkg::S_WRITE: state_d = prs_pkg::S_RESULT;
			prs_pkg::S_SCALE: begin
				if (thr_done) begin
					state_d = prs_pkg::S_WALK;
				end
			end
			prs_pkg::S_WALK: begin
				if (hit) begin
					state_d = prs_pkg::S_RESULT;
				end else if (v_s2 && at_last) begin
					state_d = prs_pkg::S_FINISH;
				end
			end
			prs_pkg::S_FINISH: state_d = prs_pkg::S_RESULT;
			prs_pkg::S_RESULT: begin
				if (!result_valid_q || !result_stall) begin
					state_d = prs_pkg::S_IDLE;
				end
			end
			default: state_d = prs_pkg::S_IDLE;
		endcase
	end

	// ---------------- State outputs ----------------
	always_comb begin
		ord_we     = 1'b0;
		ord_waddr  = clr_q;
		ord_wdata  = clr_q;
		prop_we    = 1'b0;
		prop_waddr = clr_q;
		prop_wdata = '0;
		prop_raddr = ord_rdata;
		thr_start  = 1'b0;
		load_res   = 1'b0;
		unique case (state_q)
			prs_pkg::S_CLEAR: begin
				ord_we  = 1'b1;
				prop_we = 1'b1;
			end
			prs_pkg::S_IDLE: begin
				prop_raddr = r_wide[AW-1:0];
				thr_start  = accept && (item.operation == prs_pkg::OP_SELECT) &&
				             (total_q != '0);
			end
			prs_pkg::S_WRITE: begin
				prop_we    = wr_ok_q;
				prop_waddr = wr_addr_q;
				prop_wdata = wr_prop_q;
			end
			prs_pkg::S_SCALE: begin
			end
			prs_pkg::S_WALK: begin
				// The entry one place back is final once the current one is seen.
				ord_we    = v_s2 && !first;
				ord_waddr = pos_s2 - 1'b1;
				ord_wdata = (!hit && swap) ? id_s2 : held_id_q;
			end
			prs_pkg::S_FINISH: begin
				ord_we    = 1'b1;
				ord_waddr = last_pos;
				ord_wdata = held_id_q;
			end
			prs_pkg::S_RESULT: begin
				load_res = !result_valid_q || !result_stall;
			end
			default: begin
			end
		endcase
	end

	// ---------------- Control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= prs_pkg::S_CLEAR;
			clr_q          <= '0;
			num_q          <= prs_pkg::NUM_W'(1);
			total_q        <= '0;
			iss_act_q      <= 1'b0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == prs_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				num_q <= cfg_wdata;
			end
			if (state_q == prs_pkg::S_WRITE && wr_ok_q) begin
				total_q <= total_q - TOT_W'(prop_rdata) + TOT_W'(wr_prop_q);
			end
			if (thr_start) begin
				iss_act_q <= 1'b1;
			end else if (state_q == prs_pkg::S_WALK) begin
				if (hit || (iss_act_q && iss_q == last_pos)) begin
					iss_act_q <= 1'b0;
				end
			end
			v_s1 <= (state_q == prs_pkg::S_WALK) && iss_act_q && !hit;
			v_s2 <= v_s1 && !hit;
			if (load_res) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- Datapath registers ----------------
	assign sel_wide = {{prs_pkg::REACT_W{1'b0}}, res_sel_q};
	assign tot_wide = {{prs_pkg::TOTAL_OUT_W{1'b0}}, total_q};

	always_ff @(posedge clk) begin
		pos_s1 <= iss_q;
		pos_s2 <= pos_s1;
		id_s2  <= ord_rdata;
		if (accept) begin
			wr_addr_q    <= r_wide[AW-1:0];
			wr_ok_q      <= r_ok;
			wr_prop_q    <= p_sat_wide[PROP_BITS-1:0];
			res_sel_q    <= '0;
			res_status_q <= (item.operation == prs_pkg::OP_WRITE) ?
			                prs_pkg::STATUS_WRITE_DONE : prs_pkg::STATUS_NO_REACTION;
		end
		if (thr_start) begin
			iss_q <= '0;
			sum_q <= '0;
		end else if (state_q == prs_pkg::S_WALK) begin
			if (iss_act_q && !hit) begin
				iss_q <= iss_q + 1'b1;
			end
			if (hit) begin
				res_sel_q    <= id_s2;
				res_status_q <= prs_pkg::STATUS_SELECTED;
			end else if (v_s2) begin
				sum_q <= sum_n;
				if (first || !swap) begin
					held_id_q   <= id_s2;
					held_prop_q <= prop_rdata;
				end
			end
		end
		if (state_q == prs_pkg::S_FINISH) begin
			res_sel_q    <= held_id_q;
			res_status_q <= prs_pkg::STATUS_SELECTED;
		end
		if (load_res) begin
			result_q.selected_reaction <= sel_wide[prs_pkg::REACT_W-1:0];
			result_q.status            <= res_status_q;
			result_q.total_out         <= tot_wide[prs_pkg::TOTAL_OUT_W-1:0];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ---------------- Units ----------------
	prs_ram #(
		.WIDTH (AW),
		.DEPTH (MAX_REACTIONS)
	) u_order_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.raddr (iss_q),
		.rdata (ord_rdata)
	);

	prs_ram #(
		.WIDTH (PROP_BITS),
		.DEPTH (MAX_REACTIONS)
	) u_prop_ram (
		.clk   (clk),
		.we    (prop_we),
		.waddr (prop_waddr),
		.wdata (prop_wdata),
		.raddr (prop_raddr),
		.rdata (prop_rdata)
	);

	prs_threshold #(
		.TOT_W (TOT_W)
	) u_threshold (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (thr_start),
		.frac   (item.random_fraction),
		.total  (total_q),
		.done   (thr_done),
		.thr    (thr)
	);

endmodule

`default_nettype wire

>>> sim/propensity_reaction_selector_top_test.sv
// Self-checking testbench for the propensity reaction selector top level.
`default_nettype none

module propensity_reaction_selector_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = prs_pkg::MAX_REACTIONS_DEF;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 56;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		bit                        is_cfg;
		logic [prs_pkg::NUM_W-1:0] cfg_val;
		prs_pkg::item_t            it;
		bit                        fixed;
		prs_pkg::result_t          want;
	} plan_row_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [prs_pkg::NUM_W-1:0]   cfg_wdata;
	logic                        item_valid;
	logic                        item_stall;
	prs_pkg::item_t              item;
	logic                        result_valid;
	logic                        result_stall;
	prs_pkg::result_t            result;

	// Independent copy of the block state.
	logic [prs_pkg::PROP_IN_W-1:0] prop_copy [0:TABLE_DEPTH-1];
	logic [prs_pkg::REACT_W-1:0]   order_copy [0:TABLE_DEPTH-1];
	logic [63:0]                   total_copy;
	logic [prs_pkg::NUM_W-1:0]     num_copy;
	int                            active_n;

	prs_pkg::result_t pending_results [$];
	plan_row_t        plan [$];
	int               fail_count;
	bit               calm;
	int               stall_left;

	propensity_reaction_selector_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #1 clk = ~clk;

	initial begin
		#1_500_000;
		$display("FAIL propensity_reaction_selector_top");
		$finish;
	end

	function automatic int clamp_count(logic [prs_pkg::NUM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > TABLE_DEPTH)
			return TABLE_DEPTH;
		return int'(v);
	endfunction

	// Applies one item to the state copy and returns the result it causes.
	function automatic prs_pkg::result_t apply_item(prs_pkg::item_t it);
		prs_pkg::result_t              r;
		logic [79:0]                   product;
		logic [63:0]                   threshold;
		logic [63:0]                   acc;
		logic [prs_pkg::REACT_W-1:0]   cur;
		logic [prs_pkg::REACT_W-1:0]   prv;
		int                            n;
		int                            pick;
		bit                            found;
		r.selected_reaction = '0;
		if (it.operation == prs_pkg::OP_WRITE) begin
			total_copy = total_copy - prop_copy[it.reaction] + it.propensity;
			prop_copy[it.reaction] = it.propensity;
			r.status = prs_pkg::STATUS_WRITE_DONE;
		end else if (total_copy == 0) begin
			r.status = prs_pkg::STATUS_NO_REACTION;
		end else begin
			n = clamp_count(num_copy);
			product = {48'd0, it.random_fraction} * {16'd0, total_copy};
			threshold = product[79:32];
			acc = 0;
			pick = n - 1;
			found = 0;
			for (int i = 0; i < n && !found; i++) begin
				cur = order_copy[i];
				acc = acc + prop_copy[cur];
				if (acc > threshold) begin
					pick = i;
					found = 1;
				end else if (i != 0) begin
					// A heavier entry moves one place toward the front.
					prv = order_copy[i-1];
					if (prop_copy[cur] > prop_copy[prv]) begin
						order_copy[i] = prv;
						order_copy[i-1] = cur;
					end
				end
			end
			r.selected_reaction = order_copy[pick];
			r.status = prs_pkg::STATUS_SELECTED;
		end
		r.total_out = total_copy[prs_pkg::TOTAL_OUT_W-1:0];
		return r;
	endfunction

	function automatic plan_row_t mk_row(bit is_cfg, logic [prs_pkg::NUM_W-1:0] cfg_val,
			logic op, logic [prs_pkg::REACT_W-1:0] react,
			logic [prs_pkg::PROP_IN_W-1:0] prop, logic [prs_pkg::FRAC_W-1:0] frac,
			bit fixed, logic [prs_pkg::REACT_W-1:0] sel,
			logic [prs_pkg::STATUS_W-1:0] st,
			logic [prs_pkg::TOTAL_OUT_W-1:0] tot);
		plan_row_t row;
		row.is_cfg = is_cfg;
		row.cfg_val = cfg_val;
		row.it.operation = op;
		row.it.reaction = react;
		row.it.propensity = prop;
		row.it.random_fraction = frac;
		row.fixed = fixed;
		row.want.selected_reaction = sel;
		row.want.status = st;
		row.want.total_out = tot;
		return row;
	endfunction

	task automatic send_item(input prs_pkg::item_t it, input bit fixed,
			input prs_pkg::result_t want);
		prs_pkg::result_t r;
		@(negedge clk);
		item_valid = 1'b1;
		item = it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		r = apply_item(it);
		pending_results.push_back(fixed ? want : r);
	endtask

	task automatic sender_gap();
		int n;
		if (!calm && $urandom_range(0, 2) == 0) begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				@(negedge clk);
				item_valid = 1'b0;
			end
		end
	endtask

	// Writes the register once every outstanding transaction has completed.
	task automatic write_num(input logic [prs_pkg::NUM_W-1:0] v);
		@(negedge clk);
		item_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		num_copy = v;
		active_n = clamp_count(v);
	endtask

	initial begin
		result_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				result_stall = 1'b1;
				stall_left--;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(1, 3) - 1;
				result_stall = 1'b1;
			end else begin
				result_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		prs_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: reaction %0d status %0d total %h",
						result.selected_reaction, result.status, result.total_out);
			end else begin
				want = pending_results.pop_front();
				if (result.selected_reaction !== want.selected_reaction ||
						result.status !== want.status ||
						result.total_out !== want.total_out) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"mismatch: expected reaction %0d status %0d total %h, ",
							"got reaction %0d status %0d total %h"},
							want.selected_reaction, want.status, want.total_out,
							result.selected_reaction, result.status, result.total_out);
				end
			end
		end
	end

	initial begin
		logic [prs_pkg::NUM_W-1:0] phase_num [0:PHASES-1];
		plan_row_t                 row;
		prs_pkg::item_t            it;
		prs_pkg::result_t          none;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_valid = 1'b0;
		item = '0;
		none = '0;
		calm = 0;
		fail_count = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			prop_copy[i] = '0;
			order_copy[i] = prs_pkg::REACT_W'(i);
		end
		total_copy = 0;
		num_copy = 1;
		active_n = 1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: empty total, extreme propensities and fractions, register extremes.
		plan.push_back(mk_row(0, 0, prs_pkg::OP_SELECT, 0, 0, 32'h1234_5678,
			1, 0, prs_pkg::STATUS_NO_REACTION, 40'h0));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_WRITE, 0, 32'hFFFF_FFFF, 0,
			1, 0, prs_pkg::STATUS_WRITE_DONE, 40'h0_FFFF_FFFF));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_WRITE, 255, 32'hFFFF_FFFF, 0,
			1, 0, prs_pkg::STATUS_WRITE_DONE, 40'h1_FFFF_FFFE));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_SELECT, 0, 0, 32'h0,
			1, 0, prs_pkg::STATUS_SELECTED, 40'h1_FFFF_FFFE));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_SELECT, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
		plan.push_back(mk_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_SELECT, 0, 0, 32'h8000_0000, 0, 0, 0, 0));
		plan.push_back(mk_row(1, 256, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_SELECT, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_SELECT, 0, 0, 32'h1, 0, 0, 0, 0));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_WRITE, 255, 0, 0,
			1, 0, prs_pkg::STATUS_WRITE_DONE, 40'h0_FFFF_FFFF));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_WRITE, 0, 0, 32'hFFFF_FFFF,
			1, 0, prs_pkg::STATUS_WRITE_DONE, 40'h0));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_SELECT, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1, 0, prs_pkg::STATUS_NO_REACTION, 40'h0));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_WRITE, 128, 1, 0,
			1, 0, prs_pkg::STATUS_WRITE_DONE, 40'h1));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_WRITE, 3, 5, 0,
			1, 0, prs_pkg::STATUS_WRITE_DONE, 40'h6));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_WRITE, 200, 32'hFFFF_FFFF, 0,
			1, 0, prs_pkg::STATUS_WRITE_DONE, 40'h1_0000_0005));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_SELECT, 0, 0, 32'h1, 0, 0, 0, 0));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_SELECT, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_SELECT, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
		plan.push_back(mk_row(1, 511, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_SELECT, 0, 0, 32'hC000_0000, 0, 0, 0, 0));
		plan.push_back(mk_row(1, 2, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_SELECT, 0, 0, 32'h4000_0000, 0, 0, 0, 0));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_WRITE, 1, 7, 0, 0, 0, 0, 0));
		plan.push_back(mk_row(0, 0, prs_pkg::OP_SELECT, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));

		foreach (plan[k]) begin
			row = plan[k];
			if (row.is_cfg) begin
				write_num(row.cfg_val);
			end else begin
				sender_gap();
				send_item(row.it, row.fixed, row.want);
			end
		end

		// Random part: one register setting per phase, the extremes among them.
		phase_num[0] = 1;
		phase_num[1] = 256;
		phase_num[2] = 0;
		phase_num[3] = prs_pkg::NUM_W'($urandom_range(2, 8));
		phase_num[4] = 511;
		phase_num[5] = prs_pkg::NUM_W'($urandom_range(9, 64));
		phase_num[6] = prs_pkg::NUM_W'($urandom_range(257, 510));
		phase_num[7] = prs_pkg::NUM_W'($urandom_range(2, 255));
		for (int ph = 0; ph < PHASES; ph++) begin
			write_num(phase_num[ph]);
			calm = (ph == PHASES - 1);
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				it.operation = ($urandom_range(0, 99) < 45) ?
				               prs_pkg::OP_WRITE : prs_pkg::OP_SELECT;
				if ($urandom_range(0, 3) != 0)
					it.reaction = prs_pkg::REACT_W'($urandom_range(0, active_n - 1));
				else
					it.reaction = prs_pkg::REACT_W'($urandom);
				case ($urandom_range(0, 7))
					0: it.propensity = '0;
					1: it.propensity = '1;
					2, 3: it.propensity = $urandom;
					default: it.propensity = $urandom_range(1, 4000);
				endcase
				case ($urandom_range(0, 9))
					0: it.random_fraction = '0;
					1: it.random_fraction = '1;
					2: it.random_fraction = 1;
					default: it.random_fraction = $urandom;
				endcase
				sender_gap();
				send_item(it, 0, none);
			end
		end

		@(negedge clk);
		item_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("PASS propensity_reaction_selector_top");
		else
			$display("FAIL propensity_reaction_selector_top");
		$finish;
	end

endmodule

`default_nettype wire
